/* sv/ksl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the key short/long press scanner.
// No dependencies; imported by every module of the block.
package ksl_pkg;

   localparam int NUM_KEYS   = 4;
   localparam int LEVEL_BITS = 4;
   localparam int TIME_W     = 32;
   localparam int CFG_W      = 16;
   localparam int CODE_W     = 8;
   localparam int PHASE_W    = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM_TIME = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TIME    = CSR_IDX_W'(1);

   localparam logic [CFG_W-1:0] CONFIRM_TIME_RESET = CFG_W'(30);
   localparam logic [CFG_W-1:0] LONG_TIME_RESET    = CFG_W'(1000);

   localparam logic [PHASE_W-1:0] PH_RELEASED = 2'd0;
   localparam logic [PHASE_W-1:0] PH_CONFIRM  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_SHORT    = 2'd2;
   localparam logic [PHASE_W-1:0] PH_LONG     = 2'd3;

   localparam logic [CODE_W-1:0] CODE_NONE      = CODE_W'(0);
   localparam logic [CODE_W-1:0] CODE_SHORT_OFS = CODE_W'(8'h01);
   localparam logic [CODE_W-1:0] CODE_LONG_OFS  = CODE_W'(8'h81);

   localparam int LANE_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   typedef struct packed {
      logic              report;
      logic [CODE_W-1:0] code;
   } lane_res_type;

   typedef lane_res_type [NUM_KEYS-1:0] lane_vec_type;

   typedef struct packed {
      logic [NUM_KEYS-1:0] commit;
      logic [CODE_W-1:0]   code;
   } merge_res_type;

endpackage

/* sv/ksl_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for scan requests, key codes and CSR writes.
// Depends on ksl_pkg for field widths.
interface ksl_req_if;
   logic                         valid;
   logic                         ready;
   logic [ksl_pkg::LEVEL_BITS-1:0] key_levels;
   logic [ksl_pkg::TIME_W-1:0]     now_ms;
   modport source (output valid, key_levels, now_ms, input ready);
   modport sink   (input valid, key_levels, now_ms, output ready);
endinterface

interface ksl_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ksl_pkg::CODE_W-1:0] key_code;
   modport source (output valid, key_code, input ready);
   modport sink   (input valid, key_code, output ready);
endinterface

interface ksl_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ksl_pkg::CSR_IDX_W-1:0]  index;
   logic [ksl_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/key_short_long_press_scanner.sv */
`timescale 1ns / 1ps
// Key short/long press scanner top level: CSRs, key lanes, merge, output register.
// key_code is registered and valid in the cycle after the scan transaction is accepted.
// Throughput: one scan per cycle; each lane does one subtract and compare per scan.
// A stalled result blocks the next scan only while its register is still full.
// Reset (synchronous): all keys released, start times zero, confirm 30 ms, long 1000 ms.
module key_short_long_press_scanner (
   input  logic      clock,
   input  logic      reset,
   ksl_req_if.sink   req_chan,
   ksl_rsp_if.source rsp_chan,
   ksl_csr_if.sink   csr_chan
);
   import ksl_pkg::*;

   logic [CFG_W-1:0]  confirm_ff, confirm_in;
   logic [CFG_W-1:0]  long_ff, long_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              accept;
   lane_vec_type      lanes;
   merge_res_type     merged;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      confirm_in = confirm_ff;
      long_in    = long_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_CONFIRM_TIME: confirm_in = csr_chan.data[CFG_W-1:0];
            CSR_LONG_TIME:    long_in    = csr_chan.data[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
      logic released;
      if (i < LEVEL_BITS) begin : g_bit
         assign released = req_chan.key_levels[i];
      end else begin : g_nobit
         assign released = 1'b1;
      end
      ksl_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .lane_idx      (LANE_IDX_W'(i)),
         .released      (released),
         .now_ms        (req_chan.now_ms),
         .confirm_limit (confirm_ff),
         .long_time     (long_ff),
         .commit        (merged.commit[i]),
         .result        (lanes[i])
      );
   end

   ksl_merge u_merge (
      .accept (accept),
      .lanes  (lanes),
      .merged (merged)
   );

   assign rsp_valid_in = accept ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   assign code_in      = accept ? merged.code : code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_ff   <= CONFIRM_TIME_RESET;
         long_ff      <= LONG_TIME_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         confirm_ff   <= confirm_in;
         long_ff      <= long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.key_code = code_ff;

endmodule

/* sv/ksl_lane.sv */
`timescale 1ns / 1ps
// One key lane: phase machine and press start time, with candidate code.
// Depends on ksl_pkg.
module ksl_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ksl_pkg::LANE_IDX_W-1:0]   lane_idx,
   input  logic                             released,
   input  logic [ksl_pkg::TIME_W-1:0]       now_ms,
   input  logic [ksl_pkg::CFG_W-1:0]        confirm_limit,
   input  logic [ksl_pkg::CFG_W-1:0]        long_time,
   input  logic                             commit,
   output ksl_pkg::lane_res_type            result
);
   import ksl_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic [TIME_W-1:0]  elapsed;
   logic [CODE_W-1:0]  idx_ext;

   assign elapsed = now_ms - start_ff;
   assign idx_ext = CODE_W'(lane_idx);

   always_comb begin
      phase_in      = phase_ff;
      start_in      = start_ff;
      result.report = 1'b0;
      result.code   = CODE_NONE;
      case (phase_ff)
         PH_RELEASED: begin
            if (!released) begin
               phase_in = PH_CONFIRM;
               start_in = now_ms;
            end
         end
         PH_CONFIRM: begin
            if (released) begin
               phase_in = PH_RELEASED;
            end else if (elapsed > TIME_W'(confirm_limit)) begin
               phase_in = PH_SHORT;
            end
         end
         PH_SHORT: begin
            if (released) begin
               phase_in      = PH_RELEASED;
               result.report = 1'b1;
               result.code   = idx_ext + CODE_SHORT_OFS;
            end else if (elapsed > TIME_W'(long_time)) begin
               phase_in = PH_LONG;
            end
         end
         default: begin
            if (released) begin
               phase_in      = PH_RELEASED;
               result.report = 1'b1;
               result.code   = idx_ext + CODE_LONG_OFS;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RELEASED;
         start_ff <= '0;
      end else if (commit) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
      end
   end

endmodule

/* sv/ksl_merge.sv */
`timescale 1ns / 1ps
// Priority merge: first reporting lane wins, lanes after it hold state.
// Depends on ksl_pkg.
module ksl_merge (
   input  logic                   accept,
   input  ksl_pkg::lane_vec_type  lanes,
   output ksl_pkg::merge_res_type merged
);
   import ksl_pkg::*;

   logic blocked;

   always_comb begin
      blocked       = 1'b0;
      merged.commit = '0;
      merged.code   = CODE_NONE;
      for (int i = 0; i < NUM_KEYS; i++) begin
         merged.commit[i] = accept && !blocked;
         if (!blocked && lanes[i].report) begin
            merged.code = lanes[i].code;
         end
         blocked = blocked | lanes[i].report;
      end
   end

endmodule

/* sv/ksl_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the key scanner, attached by bind to the top level.
// Depends on ksl_pkg.
module ksl_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ksl_pkg::CODE_W-1:0] key_code
);
   import ksl_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted scan gave no result");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("scan stalled without a pending result");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && key_code != CODE_NONE) |->
      (key_code[CODE_W-2:0] != '0 && key_code[CODE_W-2:0] <= (CODE_W-1)'(NUM_KEYS)))
      else $error("key code names no key");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(key_code)))
      else $error("stalled result changed");

endmodule

bind key_short_long_press_scanner ksl_checker u_ksl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .key_code  (rsp_chan.key_code)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for key_short_long_press_scanner: directed and random scans
// against a per-key press predictor held in a small scoreboard class.
// Depends on ksl_pkg and the ksl_if channel interfaces.
module testbench;
   import ksl_pkg::*;

   class press_scoreboard;
      logic [PHASE_W-1:0] phase [NUM_KEYS];
      logic [TIME_W-1:0]  start_ms [NUM_KEYS];
      logic [CFG_W-1:0]   confirm_ms;
      logic [CFG_W-1:0]   long_ms;
      logic [CODE_W-1:0]  code_q [$];
      int scans;
      int short_codes;
      int long_codes;
      int reg_writes;
      int errors;

      function new();
         confirm_ms = CONFIRM_TIME_RESET;
         long_ms = LONG_TIME_RESET;
         for (int i = 0; i < NUM_KEYS; i++) begin
            phase[i] = PH_RELEASED;
            start_ms[i] = '0;
         end
         scans = 0;
         short_codes = 0;
         long_codes = 0;
         reg_writes = 0;
         errors = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] value);
         reg_writes++;
         if (idx == CSR_CONFIRM_TIME) begin
            confirm_ms = value[CFG_W-1:0];
         end else if (idx == CSR_LONG_TIME) begin
            long_ms = value[CFG_W-1:0];
         end
      endfunction

      function void note_scan(input logic [LEVEL_BITS-1:0] levels,
                              input logic [TIME_W-1:0] stamp);
         logic [CODE_W-1:0] code;
         logic              up;
         logic [TIME_W-1:0] held;
         code = CODE_NONE;
         for (int i = 0; i < NUM_KEYS && code == CODE_NONE; i++) begin
            up = (i < LEVEL_BITS) ? levels[i] : 1'b1;
            held = stamp - start_ms[i];
            case (phase[i])
               PH_RELEASED: begin
                  if (!up) begin
                     phase[i] = PH_CONFIRM;
                     start_ms[i] = stamp;
                  end
               end
               PH_CONFIRM: begin
                  if (up) begin
                     phase[i] = PH_RELEASED;
                  end else if (held > TIME_W'(confirm_ms)) begin
                     phase[i] = PH_SHORT;
                  end
               end
               PH_SHORT: begin
                  if (up) begin
                     phase[i] = PH_RELEASED;
                     code = CODE_SHORT_OFS + CODE_W'(i);
                  end else if (held > TIME_W'(long_ms)) begin
                     phase[i] = PH_LONG;
                  end
               end
               default: begin
                  if (up) begin
                     phase[i] = PH_RELEASED;
                     code = CODE_LONG_OFS + CODE_W'(i);
                  end
               end
            endcase
         end
         scans++;
         if (code >= CODE_LONG_OFS) begin
            long_codes++;
         end else if (code != CODE_NONE) begin
            short_codes++;
         end
         code_q.push_back(code);
      endfunction

      function void check_code(input logic [CODE_W-1:0] actual);
         logic [CODE_W-1:0] want;
         if (code_q.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected key code %02h with no scan pending", actual);
            end
            return;
         end
         want = code_q.pop_front();
         if (actual !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("key code mismatch: expected %02h, got %02h", want, actual);
            end
         end
      endfunction

      function int pending();
         return code_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   req_idle_on;
   bit   rsp_idle_on;
   bit   hold_req;
   logic [TIME_W-1:0] scan_clock;

   press_scoreboard sb = new();

   ksl_req_if req_if();
   ksl_rsp_if rsp_if();
   ksl_csr_if csr_if();

   key_short_long_press_scanner dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // result side: check, then pick ready for the next edge
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            sb.check_code(rsp_if.key_code);
         end
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !(rsp_idle_on && $urandom_range(99) < 31);
         end
      end
   end

   task automatic wait_drained();
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic send_scan(input logic [LEVEL_BITS-1:0] levels,
                            input logic [TIME_W-1:0] stamp);
      if (req_idle_on && $urandom_range(99) < 31) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while (req_idle_on && $urandom_range(99) < 31);
      end
      req_if.valid <= 1'b1;
      req_if.key_levels <= levels;
      req_if.now_ms <= stamp;
      do @(posedge clock); while (!req_if.ready);
      sb.note_scan(levels, stamp);
   endtask

   // drain, then write both registers with junk high bits plus stray indexes
   task automatic apply_settings(input logic [CFG_W-1:0] confirm_val,
                                 input logic [CFG_W-1:0] long_val);
      logic [CSR_IDX_W-1:0]  idx_list [4];
      logic [CSR_DATA_W-1:0] val_list [4];
      wait_drained();
      repeat (3) @(posedge clock);
      idx_list[0] = CSR_IDX_W'($urandom_range(2, 255));
      idx_list[1] = CSR_CONFIRM_TIME;
      idx_list[2] = CSR_IDX_W'($urandom_range(2, 255));
      idx_list[3] = CSR_LONG_TIME;
      val_list[0] = $urandom;
      val_list[1] = {CFG_W'($urandom), confirm_val};
      val_list[2] = $urandom;
      val_list[3] = {CFG_W'($urandom), long_val};
      for (int k = 0; k < 4; k++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= idx_list[k];
         csr_if.data <= val_list[k];
         do @(posedge clock); while (!csr_if.ready);
         sb.write_reg(idx_list[k], val_list[k]);
      end
      csr_if.valid <= 1'b0;
   endtask

   // mostly key presses held over advancing time, a few noise and wrap scans
   task automatic run_scans(input int count, input int step_max, input bit pressure);
      logic [LEVEL_BITS-1:0] lv;
      logic [TIME_W-1:0]     t;
      lv = '1;
      t = scan_clock;
      if (pressure) begin
         hold_req = 1'b1;
      end
      for (int k = 0; k < count; k++) begin
         int pick;
         pick = $urandom_range(99);
         if (pick < 5) begin
            lv = LEVEL_BITS'($urandom);
            t = $urandom;
         end else if (pick < 7) begin
            t = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, step_max));
         end else begin
            for (int b = 0; b < LEVEL_BITS; b++) begin
               if ($urandom_range(15) == 0) begin
                  lv[b] = ~lv[b];
               end
            end
            t = t + TIME_W'($urandom_range(0, step_max));
         end
         if (pressure && k == count / 2) begin
            req_if.valid <= 1'b0;
            wait_drained();
         end
         send_scan(lv, t);
      end
      req_if.valid <= 1'b0;
      scan_clock = t;
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.key_levels = '1;
      req_if.now_ms = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      hold_req = 1'b0;
      scan_clock = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: short, confirm release, all-long chain, wrap, backward time
      send_scan(4'hF, 32'd0);
      send_scan(4'hE, 32'd100);
      send_scan(4'hE, 32'd131);
      send_scan(4'hF, 32'd140);
      send_scan(4'hE, 32'd200);
      send_scan(4'hE, 32'd230);
      send_scan(4'hF, 32'd235);
      send_scan(4'h0, 32'd300);
      send_scan(4'h0, 32'd400);
      send_scan(4'h0, 32'd1301);
      send_scan(4'hF, 32'd1310);
      send_scan(4'hF, 32'd1311);
      send_scan(4'hF, 32'd1312);
      send_scan(4'hF, 32'd1313);
      send_scan(4'hF, 32'd1314);
      send_scan(4'h7, 32'd2000);
      send_scan(4'h7, 32'd2031);
      send_scan(4'hF, 32'd2032);
      send_scan(4'hB, 32'hFFFF_FFF0);
      send_scan(4'hB, 32'h0000_0010);
      send_scan(4'hF, 32'h0000_0011);
      send_scan(4'hD, 32'd5000);
      send_scan(4'hD, 32'd4999);
      send_scan(4'hD, 32'd4998);
      send_scan(4'hF, 32'd4999);
      req_if.valid <= 1'b0;
      scan_clock = 32'd6000;

      apply_settings(CONFIRM_TIME_RESET, LONG_TIME_RESET);
      run_scans(400, 120, 1'b1);

      apply_settings(CFG_W'(0), CFG_W'(0));
      run_scans(300, 3, 1'b0);

      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      apply_settings(CFG_W'(16'hFFFF), CFG_W'(16'hFFFF));
      run_scans(300, 20000, 1'b0);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;

      for (int p = 0; p < 4; p++) begin
         apply_settings(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 300)));
         run_scans(250, 40, 1'b0);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      sb.errors += sb.pending();
      $display("covered %0d scans with %0d short and %0d long releases",
               sb.scans, sb.short_codes, sb.long_codes);
      $display("over %0d register writes, including zero, maximum and stray indexes",
               sb.reg_writes);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
